@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned IdW    = 10;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 16;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 112;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // One table slot.
  typedef struct packed {
    logic              done;
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] remaining;
    logic [BurstW-1:0] burst;
  } entry_t;

  // Input transfer, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic [BurstW-1:0] burst_time;
    logic [ArrW-1:0]   arrival_time;
    logic [PrioW-1:0]  priority_req;
    logic [IdW-1:0]    task_id;
    cmd_e              command;
  } in_t;

  // Result transfer, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]       pad;
    logic             table_full;
    logic             all_done;
    logic [TimeW-1:0] waiting_time;
    logic [TimeW-1:0] turnaround_time;
    logic [TimeW-1:0] exit_time;
    logic             task_finished;
    logic [IdW-1:0]   running_id;
    logic [TimeW-1:0] current_time;
  } out_t;

endpackage

@@ rtl/pps_task_mem.sv @@
`timescale 1ns / 1ps

module pps_task_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  pps_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output pps_pkg::entry_t       rdata_o
);
  import pps_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pps_compare.sv @@
`timescale 1ns / 1ps

module pps_compare (
  input  logic [pps_pkg::TimeW-1:0] time_now_i,
  input  pps_pkg::entry_t           cand_i,
  input  pps_pkg::entry_t           best_i,
  input  logic                      best_valid_i,
  output logic                      take_o
);
  import pps_pkg::*;

  logic eligible;
  logic beats;

  // Lower priority number wins, then earlier arrival; equal keeps the lower slot.
  assign eligible = !cand_i.done && ({(TimeW-ArrW)'(0), cand_i.arrival} <= time_now_i);
  assign beats    = (cand_i.prio < best_i.prio) ||
                    ((cand_i.prio == best_i.prio) && (cand_i.arrival < best_i.arrival));
  assign take_o   = eligible && (!best_valid_i || beats);

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// Preemptive priority scheduler. Each input transfer carries one command:
// load a task into the next free slot, advance one time tick, or clear the
// table and time. Every command returns exactly one result transfer. On a
// tick the sequencer walks the task table one slot per cycle through a
// single comparator, keeping the best arrived, unfinished task (lowest
// priority number, then earliest arrival, then lowest slot); the winner
// loses one unit of burst and, if it finishes, its exit, turnaround and
// waiting times are reported. A tick runs through SCAN, UPDATE, TURN, WAIT
// and RESP in order; load, clear and the unused command go straight to
// RESP. s_axis_tready is high only between commands; a finished result
// waits in the output register and the next command is taken meanwhile.
// A burst of 0 loads as 1, time saturates at 2^24-1, and a load into a
// full table is refused with table_full set. Slot storage needs no
// clearing pass: only slots below the fill count are ever read.

module preemptive_priority_scheduler #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // command[1:0], task_id[11:2], priority_req[19:12], arrival_time[35:20],
  // burst_time[51:36], zero fill[55:52]
  input  logic [pps_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // current_time[23:0], running_id[33:24], task_finished[34],
  // exit_time[58:35], turnaround_time[82:59], waiting_time[106:83],
  // all_done[107], table_full[108], zero fill[111:109]
  output logic [pps_pkg::OutDataW-1:0]  m_axis_tdata
);
  import pps_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TASKS);

  // one-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_UPDATE = 7'b0000100,
    ST_TURN   = 7'b0001000,
    ST_WAIT   = 7'b0010000,
    ST_RESP   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  entry_count_q, entry_count_d;
  logic [CntW-1:0]  finished_count_q, finished_count_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [CntW-1:0]  scan_q, scan_d;       // next slot to read
  logic             pend_q, pend_d;       // read data arrives this cycle
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;   // slot of the data in flight
  entry_t           best_q, best_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic             best_valid_q, best_valid_d;
  out_t             res_q, res_d;         // result under construction
  logic             m_valid_q, m_valid_d;
  out_t             m_data_q, m_data_d;

  // memory port
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  logic             take;
  logic             accept;
  in_t              in_w;
  logic [TimeW-1:0] time_next;
  logic [BurstW-1:0] rem_next;
  logic [BurstW-1:0] load_burst;
  logic [TimeW-1:0] arr_ext, burst_ext;

  assign in_w          = in_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign time_next  = (time_q != TimeMax) ? time_q + TimeW'(1) : time_q;
  assign rem_next   = (best_q.remaining != '0) ? best_q.remaining - BurstW'(1)
                                                : best_q.remaining;
  assign load_burst = (in_w.burst_time != '0) ? in_w.burst_time : BurstW'(1);
  assign arr_ext    = {(TimeW-ArrW)'(0), best_q.arrival};
  assign burst_ext  = {(TimeW-BurstW)'(0), best_q.burst};

  pps_task_mem #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pps_compare u_cmp (
    .time_now_i   (time_q),
    .cand_i       (mem_rdata),
    .best_i       (best_q),
    .best_valid_i (best_valid_q),
    .take_o       (take)
  );

  always_comb begin
    state_d          = state_q;
    entry_count_d    = entry_count_q;
    finished_count_d = finished_count_q;
    time_d           = time_q;
    scan_d           = scan_q;
    pend_d           = 1'b0;
    rd_idx_d         = rd_idx_q;
    best_d           = best_q;
    best_idx_d       = best_idx_q;
    best_valid_d     = best_valid_q;
    res_d            = res_q;
    m_valid_d        = m_valid_q;
    m_data_d         = m_data_q;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    // output register drains independently of the sequencer
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (in_w.command)
            CMD_LOAD: begin
              if (entry_count_q == CntMax) begin
                res_d.table_full = 1'b1;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = entry_count_q[IdxW-1:0];
                mem_wdata.done    = 1'b0;
                mem_wdata.id      = in_w.task_id;
                mem_wdata.prio    = in_w.priority_req;
                mem_wdata.arrival = in_w.arrival_time;
                mem_wdata.remaining = load_burst;
                mem_wdata.burst   = load_burst;
                entry_count_d     = entry_count_q + CntW'(1);
              end
              state_d = ST_RESP;
            end
            CMD_TICK: begin
              scan_d       = '0;
              best_valid_d = 1'b0;
              state_d      = ST_SCAN;
            end
            CMD_CLEAR: begin
              entry_count_d    = '0;
              finished_count_d = '0;
              time_d           = '0;
              state_d          = ST_RESP;
            end
            CMD_NONE: begin
              state_d = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one slot compared per cycle against the running best
        if (pend_q && take) begin
          best_d       = mem_rdata;
          best_idx_d   = rd_idx_q;
          best_valid_d = 1'b1;
        end
        if (scan_q < entry_count_q) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q[IdxW-1:0];
          rd_idx_d  = scan_q[IdxW-1:0];
          scan_d    = scan_q + CntW'(1);
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        time_d = time_next;
        res_d  = '0;
        if (best_valid_q) begin
          res_d.running_id    = best_q.id;
          mem_we              = 1'b1;
          mem_waddr           = best_idx_q;
          mem_wdata           = best_q;
          mem_wdata.remaining = rem_next;
          mem_wdata.done      = (rem_next == '0);
          if (rem_next == '0) begin
            res_d.task_finished = 1'b1;
            res_d.exit_time     = time_next;
            finished_count_d    = finished_count_q + CntW'(1);
          end
        end
        state_d = ST_TURN;
      end

      ST_TURN: begin
        if (res_q.task_finished && (res_q.exit_time >= arr_ext)) begin
          res_d.turnaround_time = res_q.exit_time - arr_ext;
        end
        state_d = ST_WAIT;
      end

      ST_WAIT: begin
        if (res_q.task_finished && (res_q.turnaround_time >= burst_ext)) begin
          res_d.waiting_time = res_q.turnaround_time - burst_ext;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d              = res_q;
          m_data_d.pad          = '0;
          m_data_d.current_time = time_q;
          m_data_d.all_done     = (finished_count_q == entry_count_q);
          m_valid_d             = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      entry_count_q    <= '0;
      finished_count_q <= '0;
      time_q           <= '0;
      scan_q           <= '0;
      pend_q           <= 1'b0;
      best_valid_q     <= 1'b0;
      m_valid_q        <= 1'b0;
    end else begin
      state_q          <= state_d;
      entry_count_q    <= entry_count_d;
      finished_count_q <= finished_count_d;
      time_q           <= time_d;
      scan_q           <= scan_d;
      pend_q           <= pend_d;
      best_valid_q     <= best_valid_d;
      m_valid_q        <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    m_data_q   <= m_data_d;
  end

endmodule

@@ rtl/pps_checker.sv @@
`timescale 1ns / 1ps

module pps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pps_pkg::OutDataW-1:0] m_axis_tdata
);
  import pps_pkg::*;

  out_t res;
  assign res = out_t'(m_axis_tdata);

  // one command at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  // stalled result holds
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // timing fields only accompany a finished task
  a_times_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.task_finished) |->
      (res.exit_time == '0 && res.turnaround_time == '0 && res.waiting_time == '0))
    else $error("timing fields set without a finished task");

  // waiting never exceeds turnaround, turnaround never exceeds exit
  a_time_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.task_finished) |->
      (res.waiting_time <= res.turnaround_time && res.turnaround_time <= res.exit_time))
    else $error("finished task times out of order");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

@@ sim/tb_preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned ITEM_TARGET = 1350;
  // no transfer on either side for this long means the block is hung
  localparam int unsigned QUIET_LIMIT = 4000;
  // receiver hold-off used to back the block up
  localparam int unsigned LONG_HOLD   = 400;
  // a tick scans every filled slot; cover the largest table
  localparam int unsigned TAIL_CYCLES = 2 * (SLOTS + 7);

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  always #2 clk_i = ~clk_i;

  preemptive_priority_scheduler #(
    .MAX_TASKS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------------------------------------------------------------
  // Scheduler shadow: task table, fill and finish counts, current time
  // ---------------------------------------------------------------------
  entry_t           task_tab [SLOTS];
  int unsigned      fill_cnt = 0;
  int unsigned      done_cnt = 0;
  logic [TimeW-1:0] now_t    = '0;

  out_t pending_results [$];
  int   mismatch_cnt = 0;
  int   items_sent   = 0;
  int   burst_left   = 0;
  bit   rx_hold_req  = 1'b0;

  // Apply one command to the shadow table and return the result it causes.
  function automatic out_t schedule_step(input in_t item);
    out_t              r;
    int                best;
    logic [BurstW-1:0] b;
    logic [TimeW-1:0]  turn;
    r    = '0;
    best = -1;
    case (item.command)
      CMD_LOAD: begin
        if (fill_cnt >= SLOTS) begin
          r.table_full = 1'b1;
        end else begin
          b = (item.burst_time == '0) ? BurstW'(1) : item.burst_time;
          task_tab[fill_cnt] = '{done: 1'b0, id: item.task_id, prio: item.priority_req,
                                 arrival: item.arrival_time, remaining: b, burst: b};
          fill_cnt++;
        end
      end
      CMD_TICK: begin
        // lowest priority number, then earliest arrival, then lowest slot
        for (int i = 0; i < fill_cnt; i++) begin
          if (task_tab[i].done || TimeW'(task_tab[i].arrival) > now_t) continue;
          if (best < 0 || task_tab[i].prio < task_tab[best].prio ||
              (task_tab[i].prio == task_tab[best].prio &&
               task_tab[i].arrival < task_tab[best].arrival)) begin
            best = i;
          end
        end
        if (now_t != TimeMax) now_t++;
        if (best >= 0) begin
          r.running_id = task_tab[best].id;
          if (task_tab[best].remaining != '0) task_tab[best].remaining--;
          if (task_tab[best].remaining == '0) begin
            task_tab[best].done = 1'b1;
            done_cnt++;
            r.task_finished = 1'b1;
            r.exit_time     = now_t;
            turn = (now_t >= TimeW'(task_tab[best].arrival)) ?
                   now_t - TimeW'(task_tab[best].arrival) : '0;
            r.turnaround_time = turn;
            r.waiting_time    = (turn >= TimeW'(task_tab[best].burst)) ?
                                turn - TimeW'(task_tab[best].burst) : '0;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) task_tab[i].done = 1'b0;
        fill_cnt = 0;
        done_cnt = 0;
        now_t    = '0;
      end
      default: ;
    endcase
    r.current_time = now_t;
    r.all_done     = (done_cnt == fill_cnt);
    return r;
  endfunction

  function automatic in_t make_item(input cmd_e cmd, input logic [IdW-1:0] id,
                                    input logic [PrioW-1:0] prio,
                                    input logic [ArrW-1:0] arr,
                                    input logic [BurstW-1:0] burst);
    in_t it;
    it              = '0;
    it.command      = cmd;
    it.task_id      = id;
    it.priority_req = prio;
    it.arrival_time = arr;
    it.burst_time   = burst;
    return it;
  endfunction

  // Small, early tasks so that a run actually completes; tight priorities
  // half the time to force ties.
  function automatic in_t short_task();
    logic [PrioW-1:0] p;
    p = ($urandom_range(0, 1) == 0) ? PrioW'($urandom_range(0, 3)) : PrioW'($urandom);
    return make_item(CMD_LOAD, IdW'($urandom_range(1, 1023)), p,
                     ArrW'($urandom_range(0, 20)), BurstW'($urandom_range(0, 6)));
  endfunction

  function automatic in_t tick_item();
    return make_item(CMD_TICK, IdW'($urandom), PrioW'($urandom), ArrW'($urandom),
                     BurstW'($urandom));
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of transfers with random gaps in between
  // ---------------------------------------------------------------------
  task automatic send_item(input in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(schedule_step(item));
    items_sent++;
    burst_left--;
  endtask

  // Sender pauses until every result is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus a long hold on request
  // ---------------------------------------------------------------------
  initial begin : rx_pattern
    int mode;
    int run_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 3);
        run_len = $urandom_range(4, 40);
        for (int k = 0; k < run_len; k++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= k[0];
            2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [TimeW-1:0] want,
                                      input logic [TimeW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    out_t want;
    out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("current_time",    want.current_time,    got.current_time);
        check_field("running_id",      TimeW'(want.running_id), TimeW'(got.running_id));
        check_field("task_finished",   TimeW'(want.task_finished),
                    TimeW'(got.task_finished));
        check_field("exit_time",       want.exit_time,       got.exit_time);
        check_field("turnaround_time", want.turnaround_time, got.turnaround_time);
        check_field("waiting_time",    want.waiting_time,    got.waiting_time);
        check_field("all_done",        TimeW'(want.all_done), TimeW'(got.all_done));
        check_field("table_full",      TimeW'(want.table_full), TimeW'(got.table_full));
      end
    end
  end

  // Watchdog: counts cycles without any transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty table, idle tick, zero burst, id zero, field extremes, priority
  // and arrival ties, preemption by a later arrival, unused command.
  task automatic test_directed();
    send_item(make_item(CMD_NONE, '1, '1, '1, '1));
    send_item(make_item(CMD_TICK, '0, '0, '0, '0));
    send_item(make_item(CMD_CLEAR, '1, '1, '1, '1));
    send_item(make_item(CMD_LOAD, '0, '0, '0, '0));
    send_item(make_item(CMD_LOAD, '1, '1, '1, '1));
    send_item(make_item(CMD_LOAD, 10'd5, 8'd3, 16'd1, 16'd2));
    send_item(make_item(CMD_LOAD, 10'd6, 8'd3, 16'd1, 16'd1));
    send_item(make_item(CMD_LOAD, 10'd7, 8'd3, 16'd0, 16'd1));
    send_item(make_item(CMD_LOAD, 10'd8, 8'd1, 16'd4, 16'd1));
    repeat (8) send_item(tick_item());
    send_item(make_item(CMD_NONE, '0, '0, '0, '0));
    send_item(make_item(CMD_CLEAR, '0, '0, '0, '0));
    send_item(tick_item());
    drain_results();
  endtask

  // Fill every slot, refuse one more load, scan the full table once.
  task automatic test_table_full();
    send_item(make_item(CMD_CLEAR, '0, '0, '0, '0));
    repeat (SLOTS) send_item(short_task());
    send_item(short_task());
    send_item(tick_item());
    send_item(make_item(CMD_NONE, '0, '0, '0, '0));
    send_item(make_item(CMD_CLEAR, '0, '0, '0, '0));
    drain_results();
  endtask

  // Receiver holds off while commands keep coming, so the block backs up
  // and stalls its input.
  task automatic test_backpressure();
    send_item(make_item(CMD_CLEAR, '0, '0, '0, '0));
    repeat (4) send_item(short_task());
    rx_hold_req = 1'b1;
    repeat (30) send_item(tick_item());
    drain_results();
  endtask

  // Mostly complete runs (clear, loads, ticks until done, with late loads
  // mid-run), the rest raw transfers with every field random.
  task automatic test_random_traffic();
    int n;
    int guard;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(make_item(CMD_CLEAR, IdW'($urandom), PrioW'($urandom), ArrW'($urandom),
                            BurstW'($urandom)));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        repeat (n) send_item(short_task());
        guard = 0;
        while (done_cnt != fill_cnt && guard < 400) begin
          if ($urandom_range(0, 15) == 0) send_item(short_task());
          else send_item(tick_item());
          guard++;
        end
        repeat ($urandom_range(0, 2)) send_item(tick_item());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(make_item(cmd_e'($urandom_range(0, 3)), IdW'($urandom), PrioW'($urandom),
                              ArrW'($urandom), BurstW'($urandom)));
        end
      end
    end
    drain_results();
  endtask

  initial begin : main
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pps_pkg.sv
rtl/pps_task_mem.sv
rtl/pps_compare.sv
rtl/preemptive_priority_scheduler.sv
rtl/pps_checker.sv
sim/tb_preemptive_priority_scheduler.sv
